FILE: hdl/mbg_pkg.sv
// Package for the maze backtracker generator: item types, event and command codes,
// controller/datapath command and status structs, and small helper functions.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package mbg_pkg;

    // Field widths fixed by the item format.
    localparam int COORD_W    = 7;
    localparam int PICK_W     = 8;
    localparam int EVENT_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int CMP_W      = 9;
    localparam int EPOCH_W    = 4;

    // Command codes carried by an input item.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Event codes carried by a result item.
    localparam logic [EVENT_W-1:0] EV_STARTED   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_CARVED    = 2'd1;
    localparam logic [EVENT_W-1:0] EV_BACKTRACK = 2'd2;
    localparam logic [EVENT_W-1:0] EV_FINISHED  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0] GRID_RESET     = 7'd65;

    // Neighbor directions in search order.
    localparam logic [1:0] DIR_W = 2'd0;
    localparam logic [1:0] DIR_N = 2'd1;
    localparam logic [1:0] DIR_E = 2'd2;
    localparam logic [1:0] DIR_S = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [PICK_W-1:0] pick;
    } t_in;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [COORD_W-1:0] wall_x;
        logic [COORD_W-1:0] wall_y;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;        // latch pick of a step item
        logic emit_finish;   // result: finished
        logic epoch_inc;     // advance the visited-map epoch
        logic sweep;         // clear one visited-map entry
        logic start_commit;  // seed the maze at cell (1,1)
        logic rd_far;        // 0: read west/north, 1: read east/south
        logic capture_wn;    // hold the west/north visited bits
        logic decide;        // carve or pop
        logic pop_load;      // load the new stack top after a pop
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic depth_zero;
        logic deep;          // more than one entry on the stack
        logic epoch_max;
        logic sweep_last;
        logic has_cand;
    } t_sts;

    // Number of cells along one axis for a configured grid size.
    function automatic logic [CMP_W-1:0] cells_along(input logic [CFG_DATA_W-1:0] size,
                                                    input logic [CMP_W-1:0] max_cells);
        logic [CFG_DATA_W-1:0] s;
        logic [CMP_W-1:0]      half;
        s = size;
        if (!s[0] && (s != '0)) begin
            s = s - 7'd1;
        end
        if (s < 7'd3) begin
            s = 7'd3;
        end
        half = CMP_W'(s[CFG_DATA_W-1:1]);
        if (half > max_cells) begin
            half = max_cells;
        end
        return half;
    endfunction

    // Remainder by three: base-4 digits are each congruent mod 3.
    function automatic logic [1:0] mod3_u8(input logic [PICK_W-1:0] v);
        logic [3:0] s;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        if (s >= 4'd6) begin
            s = s - 4'd6;
        end
        if (s >= 4'd3) begin
            s = s - 4'd3;
        end
        if (s >= 4'd3) begin
            s = s - 4'd3;
        end
        return s[1:0];
    endfunction

    // Grid position of a cell index: 2c+1, kept to the output width.
    function automatic logic [COORD_W-1:0] cell_coord(input logic [7:0] c);
        logic [8:0] t;
        t = {c, 1'b0} + 9'd1;
        return t[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/maze_backtracker_generator.sv
// Top level of the maze backtracker generator: controller plus datapath.
// Depends on mbg_pkg, mbg_ctrl and mbg_dp.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   command  | start in, busy out         | i_in (cmd, pick)
//   result   | o_strobe, one cycle        | o_res (event_res, wall/cell x,y)
//   config   | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
//
// A start item passes through S_START; a step goes through S_RDA, S_RDB and S_DEC
// when it carves or pops the last cell, and also S_POP when it pops to a lower cell
// (that state is the registered stack read); an empty-stack step is answered from idle.
// The visited map is tagged with a 4-bit epoch; each time the epoch wraps, a start
// first sweeps the map, one entry a cycle, all 2**(XW+YW) entries (1024 by default).
// After reset the same sweep runs with busy high; configuration writes are taken
// at all times. Results cannot be stalled by the receiver.
`default_nettype none

module maze_backtracker_generator #(
    parameter int MAX_CELLS_X = 32,
    parameter int MAX_CELLS_Y = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire mbg_pkg::t_in                    i_in,
    output mbg_pkg::t_out                        o_res,
    output logic                                 o_strobe,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [mbg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mbg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mbg_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // Sequencer.
    mbg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_in.cmd),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // Storage and arithmetic.
    mbg_dp #(
        .MAX_CELLS_X (MAX_CELLS_X),
        .MAX_CELLS_Y (MAX_CELLS_Y)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (sts),
        .o_res       (o_res),
        .o_strobe    (o_strobe)
    );

    // Configuration registers accept a write in any cycle.
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

FILE: hdl/mbg_ctrl.sv
// Controller of the maze backtracker generator: sequences sweep, start and step work.
// Depends on mbg_pkg for the command and status structs and the command codes.
`default_nettype none

module mbg_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_cmd,
    input  wire mbg_pkg::t_sts i_sts,
    output mbg_pkg::t_ctl      o_ctl,
    output logic               o_busy
);
    import mbg_pkg::*;

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_RDA   = 3'd3;
    localparam logic [2:0] S_RDB   = 3'd4;
    localparam logic [2:0] S_DEC   = 3'd5;
    localparam logic [2:0] S_POP   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_pend, n_pend;
    t_ctl       ctl;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        ctl     = '0;
        case (r_state)
            S_SWEEP: begin
                ctl.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    if (r_pend) begin
                        ctl.epoch_inc = 1'b1;
                        n_pend        = 1'b0;
                        n_state       = S_START;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd == CMD_START) begin
                        if (i_sts.epoch_max) begin
                            n_pend  = 1'b1;
                            n_state = S_SWEEP;
                        end else begin
                            ctl.epoch_inc = 1'b1;
                            n_state       = S_START;
                        end
                    end else if (i_sts.depth_zero) begin
                        ctl.emit_finish = 1'b1;
                    end else begin
                        ctl.accept = 1'b1;
                        n_state    = S_RDA;
                    end
                end
            end
            S_START: begin
                ctl.start_commit = 1'b1;
                n_state          = S_IDLE;
            end
            S_RDA: begin
                ctl.rd_far = 1'b0;
                n_state    = S_RDB;
            end
            S_RDB: begin
                ctl.rd_far     = 1'b1;
                ctl.capture_wn = 1'b1;
                n_state        = S_DEC;
            end
            S_DEC: begin
                ctl.decide = 1'b1;
                if (!i_sts.has_cand && i_sts.deep) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                ctl.pop_load = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register; reset begins with a sweep of the visited map.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    assign o_ctl  = ctl;
    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

FILE: hdl/mbg_dp.sv
// Datapath of the maze backtracker generator: configuration, visited map with epochs,
// cell stack, neighbor selection and the result register. Depends on mbg_pkg.
`default_nettype none

module mbg_dp #(
    parameter int MAX_CELLS_X = 32,
    parameter int MAX_CELLS_Y = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire mbg_pkg::t_ctl                   i_ctl,
    input  wire mbg_pkg::t_in                    i_in,
    input  wire logic                            i_cfg_valid,
    input  wire logic [mbg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mbg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output mbg_pkg::t_sts                        o_sts,
    output mbg_pkg::t_out                        o_res,
    output logic                                 o_strobe
);
    import mbg_pkg::*;

    localparam int XW     = (MAX_CELLS_X > 1) ? $clog2(MAX_CELLS_X) : 1;
    localparam int YW     = (MAX_CELLS_Y > 1) ? $clog2(MAX_CELLS_Y) : 1;
    localparam int VAW    = XW + YW;
    localparam int VDEPTH = 1 << VAW;
    localparam int TOTAL  = MAX_CELLS_X * MAX_CELLS_Y;
    localparam int SAW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int DW     = $clog2(TOTAL + 1);
    localparam logic [DW-1:0] DEPTH_FULL = DW'(TOTAL);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_grid_width, r_grid_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_RESET;
            r_grid_height <= GRID_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                REG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [CMP_W-1:0] ncx, ncy;
    assign ncx = cells_along(r_grid_width, CMP_W'(MAX_CELLS_X));
    assign ncy = cells_along(r_grid_height, CMP_W'(MAX_CELLS_Y));

    // Control-side registers.
    logic [EPOCH_W-1:0] r_epoch;
    logic [VAW-1:0]     r_sweep_addr;
    logic [DW-1:0]      r_depth, n_depth;
    logic               r_strobe, n_strobe;

    // Payload registers.
    logic [XW-1:0]     r_top_x, n_top_x;
    logic [YW-1:0]     r_top_y, n_top_y;
    logic [PICK_W-1:0] r_pick;
    logic              r_vis_w_hit, r_vis_n_hit;
    t_out              r_out, n_out;

    // Memories and their registered read data.
    logic [EPOCH_W-1:0] r_vis_mem [VDEPTH];
    logic [EPOCH_W-1:0] r_vis_rd0, r_vis_rd1;
    logic [VAW-1:0]     r_stk_mem [TOTAL];
    logic [VAW-1:0]     r_stk_rd;

    // Neighbor coordinates of the stack top.
    logic [XW-1:0] x_dec, x_inc;
    logic [YW-1:0] y_dec, y_inc;
    assign x_dec = r_top_x - XW'(1);
    assign x_inc = r_top_x + XW'(1);
    assign y_dec = r_top_y - YW'(1);
    assign y_inc = r_top_y + YW'(1);

    // Visited-map read addresses: west/north first, then east/south.
    logic [VAW-1:0] vis_ra0, vis_ra1;
    assign vis_ra0 = i_ctl.rd_far ? {r_top_y, x_inc} : {r_top_y, x_dec};
    assign vis_ra1 = i_ctl.rd_far ? {y_inc, r_top_x} : {y_dec, r_top_x};

    // Bounds and unvisited tests in west, north, east, south order.
    logic [CMP_W-1:0] tx9, ty9;
    logic [3:0]       cand;
    logic [2:0]       cnt;
    assign tx9 = CMP_W'(r_top_x);
    assign ty9 = CMP_W'(r_top_y);
    assign cand[DIR_W] = (r_top_x != '0) && (tx9 <= ncx) && (ty9 < ncy) && !r_vis_w_hit;
    assign cand[DIR_N] = (r_top_y != '0) && (ty9 <= ncy) && (tx9 < ncx) && !r_vis_n_hit;
    assign cand[DIR_E] = ((tx9 + CMP_W'(1)) < ncx) && (ty9 < ncy) && (r_vis_rd0 != r_epoch);
    assign cand[DIR_S] = ((ty9 + CMP_W'(1)) < ncy) && (tx9 < ncx) && (r_vis_rd1 != r_epoch);
    assign cnt = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);

    // Choice index: pick mod count.
    logic [1:0] k;
    always_comb begin
        case (cnt)
            3'd2:    k = {1'b0, r_pick[0]};
            3'd3:    k = mod3_u8(r_pick);
            3'd4:    k = r_pick[1:0];
            default: k = 2'd0;
        endcase
    end

    // The k-th candidate in search order.
    logic [1:0] sel;
    always_comb begin
        logic [2:0] run;
        logic       found;
        run   = 3'd0;
        found = 1'b0;
        sel   = DIR_W;
        for (int i = 0; i < 4; i++) begin
            if (cand[i] && !found && (run == 3'(k))) begin
                sel   = 2'(i);
                found = 1'b1;
            end
            run = run + 3'(cand[i]);
        end
    end

    // Chosen neighbor and the wall between it and the top.
    logic [XW-1:0] nb_x;
    logic [YW-1:0] nb_y;
    logic [1:0]    off_x, off_y;
    logic [9:0]    wx10, wy10;
    always_comb begin
        case (sel)
            DIR_W: begin nb_x = x_dec;   nb_y = r_top_y; off_x = 2'd0; off_y = 2'd1; end
            DIR_N: begin nb_x = r_top_x; nb_y = y_dec;   off_x = 2'd1; off_y = 2'd0; end
            DIR_E: begin nb_x = x_inc;   nb_y = r_top_y; off_x = 2'd2; off_y = 2'd1; end
            default: begin nb_x = r_top_x; nb_y = y_inc; off_x = 2'd1; off_y = 2'd2; end
        endcase
    end
    assign wx10 = (10'(r_top_x) << 1) + 10'(off_x);
    assign wy10 = (10'(r_top_y) << 1) + 10'(off_y);

    logic has_cand, push_ok, do_push, do_pop;
    assign has_cand = (cand != 4'd0);
    assign push_ok  = (r_depth < DEPTH_FULL);
    assign do_push  = i_ctl.decide && has_cand && push_ok;
    assign do_pop   = i_ctl.decide && !has_cand;

    // Visited map: one write port, two registered read ports.
    logic               vis_we;
    logic [VAW-1:0]     vis_wa;
    logic [EPOCH_W-1:0] vis_wd;
    always_comb begin
        vis_we = 1'b0;
        vis_wa = {nb_y, nb_x};
        vis_wd = r_epoch;
        if (i_ctl.sweep) begin
            vis_we = 1'b1;
            vis_wa = r_sweep_addr;
            vis_wd = '0;
        end else if (i_ctl.start_commit) begin
            vis_we = 1'b1;
            vis_wa = '0;
        end else if (i_ctl.decide && has_cand) begin
            vis_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            r_vis_mem[vis_wa] <= vis_wd;
        end
        r_vis_rd0 <= r_vis_mem[vis_ra0];
        r_vis_rd1 <= r_vis_mem[vis_ra1];
    end

    // Cell stack: one write port, one registered read port at depth minus two.
    logic [DW-1:0] depth_m2;
    assign depth_m2 = r_depth - DW'(2);

    always_ff @(posedge i_clk) begin
        if (i_ctl.start_commit) begin
            r_stk_mem[SAW'(0)] <= '0;
        end else if (do_push) begin
            r_stk_mem[r_depth[SAW-1:0]] <= {nb_y, nb_x};
        end
        r_stk_rd <= r_stk_mem[depth_m2[SAW-1:0]];
    end

    // Stack top, depth and result next values.
    always_comb begin
        n_top_x  = r_top_x;
        n_top_y  = r_top_y;
        n_depth  = r_depth;
        n_strobe = 1'b0;
        n_out    = r_out;
        if (i_ctl.start_commit) begin
            n_top_x  = '0;
            n_top_y  = '0;
            n_depth  = DW'(1);
            n_strobe = 1'b1;
            n_out    = '{EV_STARTED, '0, '0, cell_coord(8'd0), cell_coord(8'd0)};
        end else if (i_ctl.emit_finish) begin
            n_strobe = 1'b1;
            n_out    = '{EV_FINISHED, '0, '0, '0, '0};
        end else if (i_ctl.decide && has_cand) begin
            if (push_ok) begin
                n_top_x = nb_x;
                n_top_y = nb_y;
                n_depth = r_depth + DW'(1);
            end
            n_strobe = 1'b1;
            n_out    = '{EV_CARVED, wx10[COORD_W-1:0], wy10[COORD_W-1:0],
                        cell_coord(8'(n_top_x)), cell_coord(8'(n_top_y))};
        end else if (do_pop) begin
            n_depth = r_depth - DW'(1);
            if (r_depth <= DW'(1)) begin
                n_strobe = 1'b1;
                n_out    = '{EV_BACKTRACK, '0, '0, '0, '0};
            end
        end else if (i_ctl.pop_load) begin
            n_top_x  = r_stk_rd[XW-1:0];
            n_top_y  = r_stk_rd[VAW-1:XW];
            n_strobe = 1'b1;
            n_out    = '{EV_BACKTRACK, '0, '0, cell_coord(8'(r_stk_rd[XW-1:0])),
                        cell_coord(8'(r_stk_rd[VAW-1:XW]))};
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch      <= '0;
            r_sweep_addr <= '0;
            r_depth      <= '0;
            r_strobe     <= 1'b0;
        end else begin
            if (i_ctl.epoch_inc) begin
                r_epoch <= (&r_epoch) ? EPOCH_W'(1) : r_epoch + EPOCH_W'(1);
            end
            if (i_ctl.sweep) begin
                r_sweep_addr <= r_sweep_addr + VAW'(1);
            end
            r_depth  <= n_depth;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_top_x <= n_top_x;
        r_top_y <= n_top_y;
        r_out   <= n_out;
        if (i_ctl.accept) begin
            r_pick <= i_in.pick;
        end
        if (i_ctl.capture_wn) begin
            r_vis_w_hit <= (r_vis_rd0 == r_epoch);
            r_vis_n_hit <= (r_vis_rd1 == r_epoch);
        end
    end

    assign o_sts.depth_zero = (r_depth == '0);
    assign o_sts.deep       = (r_depth > DW'(1));
    assign o_sts.epoch_max  = &r_epoch;
    assign o_sts.sweep_last = &r_sweep_addr;
    assign o_sts.has_cand   = has_cand;
    assign o_res            = r_out;
    assign o_strobe         = r_strobe;

    // The stack never holds more entries than there are cells.
    a_depth_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_FULL)
        else $error("stack depth above cell count");

    // A carve result goes with exactly one push.
    a_carve_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_out.event_res == EV_CARVED)) |-> (r_depth == $past(r_depth) + DW'(1)))
        else $error("carve result without a push");

    // A start result leaves only cell (1,1) on the stack.
    a_start_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_out.event_res == EV_STARTED)) |->
        ((r_depth == DW'(1)) && (r_top_x == '0) && (r_top_y == '0)))
        else $error("start result with a wrong stack");

    // A finished result is only given for an empty stack.
    a_finish_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_out.event_res == EV_FINISHED)) |-> (r_depth == '0))
        else $error("finished result with cells on the stack");

endmodule

`default_nettype wire

FILE: bench/tb_maze_backtracker_generator.sv
// Self-checking testbench for the maze backtracker generator.
// Carves mazes through the command port and checks every result against a local maze model.
// Depends on mbg_pkg and maze_backtracker_generator.
`default_nettype none

module tb_maze_backtracker_generator;
    import mbg_pkg::*;

    localparam int CELLS_X     = 32;
    localparam int CELLS_Y     = 32;
    localparam int CELL_TOTAL  = CELLS_X * CELLS_Y;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_WAIT = 6;
    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_in                   item_in = '0;
    t_out                  res;
    logic                  res_strobe;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Maze model state, updated when an item is accepted.
    bit                    maze_visited [0:CELL_TOTAL-1];
    logic [9:0]            maze_stack [0:CELL_TOTAL-1];
    int                    maze_depth = 0;
    logic [CFG_DATA_W-1:0] grid_width_reg = GRID_RESET;
    logic [CFG_DATA_W-1:0] grid_height_reg = GRID_RESET;

    t_out maze_events_q [$];
    t_out want;
    int   events_pending = 0;
    int   items_sent = 0;
    int   fail_count = 0;
    int   idle_pct = 0;
    int   cycle_count = 0;

    maze_backtracker_generator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (item_in),
        .o_res       (res),
        .o_strobe    (res_strobe),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Number of cells along one axis; sizes are made odd and clamped to the map.
    function automatic int cells_on_axis(input logic [CFG_DATA_W-1:0] size, input int max_cells);
        int s;
        s = int'(size);
        if ((s % 2) == 0 && s > 0) begin
            s = s - 1;
        end
        if (s < 3) begin
            s = 3;
        end
        if (s > 2 * max_cells + 1) begin
            s = 2 * max_cells + 1;
        end
        return (s - 1) / 2;
    endfunction

    // Apply one item to the maze model and return the result it must produce.
    function automatic t_out predict_maze_event(input t_in it);
        t_out r;
        int   ncx, ncy, top, tx, ty, cnt, nb;
        int   cand [4];
        r = '0;
        ncx = cells_on_axis(grid_width_reg, CELLS_X);
        ncy = cells_on_axis(grid_height_reg, CELLS_Y);
        if (it.cmd == CMD_START) begin
            for (int c = 0; c < CELL_TOTAL; c++) begin
                maze_visited[c] = 1'b0;
            end
            maze_visited[0] = 1'b1;
            maze_stack[0] = '0;
            maze_depth = 1;
            r.event_res = EV_STARTED;
        end else if (maze_depth == 0) begin
            r.event_res = EV_FINISHED;
        end else begin
            top = int'(maze_stack[maze_depth-1]);
            tx = top % CELLS_X;
            ty = top / CELLS_X;
            cnt = 0;
            // Candidates in the order west, north, east, south.
            if (tx > 0 && tx - 1 < ncx && ty < ncy && !maze_visited[top-1]) begin
                cand[cnt] = top - 1;
                cnt++;
            end
            if (ty > 0 && ty - 1 < ncy && tx < ncx && !maze_visited[top-CELLS_X]) begin
                cand[cnt] = top - CELLS_X;
                cnt++;
            end
            if (tx + 1 < ncx && ty < ncy && !maze_visited[top+1]) begin
                cand[cnt] = top + 1;
                cnt++;
            end
            if (ty + 1 < ncy && tx < ncx && !maze_visited[top+CELLS_X]) begin
                cand[cnt] = top + CELLS_X;
                cnt++;
            end
            if (cnt == 0) begin
                maze_depth--;
                r.event_res = EV_BACKTRACK;
            end else begin
                nb = cand[int'(it.pick) % cnt];
                maze_visited[nb] = 1'b1;
                r.event_res = EV_CARVED;
                // The opened wall sits one position from the current cell toward the new one.
                r.wall_x = COORD_W'(2 * tx + 1 + (nb % CELLS_X) - tx);
                r.wall_y = COORD_W'(2 * ty + 1 + (nb / CELLS_X) - ty);
                maze_stack[maze_depth] = 10'(nb);
                maze_depth++;
            end
        end
        if (maze_depth > 0) begin
            top = int'(maze_stack[maze_depth-1]);
            r.cell_x = COORD_W'(2 * (top % CELLS_X) + 1);
            r.cell_y = COORD_W'(2 * (top / CELLS_X) + 1);
        end
        return r;
    endfunction

    // Result checker: every strobe must match the oldest predicted event.
    always @(posedge clk) begin
        if (rst_n && res_strobe === 1'b1) begin
            if (events_pending == 0) begin
                $error("result with no item waiting: event_res %0d", res.event_res);
                fail_count++;
            end else begin
                want = maze_events_q.pop_front();
                events_pending--;
                if (res.event_res !== want.event_res) begin
                    $error("event_res: expected %0d, got %0d", want.event_res, res.event_res);
                    fail_count++;
                end
                if (res.wall_x !== want.wall_x) begin
                    $error("wall_x: expected %0d, got %0d", want.wall_x, res.wall_x);
                    fail_count++;
                end
                if (res.wall_y !== want.wall_y) begin
                    $error("wall_y: expected %0d, got %0d", want.wall_y, res.wall_y);
                    fail_count++;
                end
                if (res.cell_x !== want.cell_x) begin
                    $error("cell_x: expected %0d, got %0d", want.cell_x, res.cell_x);
                    fail_count++;
                end
                if (res.cell_y !== want.cell_y) begin
                    $error("cell_y: expected %0d, got %0d", want.cell_y, res.cell_y);
                    fail_count++;
                end
            end
        end
    end

    // Send one item, with an optional idle gap first; start stays high for back-to-back items.
    task automatic send_item(input logic cmd, input logic [PICK_W-1:0] pick);
        t_in it;
        int  gap;
        it.cmd = cmd;
        it.pick = pick;
        gap = 0;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 5);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item_in <= it;
        do @(posedge clk); while (busy !== 1'b0);
        maze_events_q.push_back(predict_maze_event(it));
        events_pending++;
        items_sent++;
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic settle_block();
        start <= 1'b0;
        wait (events_pending == 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // One register write; valid stays high when another write follows.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        if (idx == REG_GRID_WIDTH) begin
            grid_width_reg = data;
        end else if (idx == REG_GRID_HEIGHT) begin
            grid_height_reg = data;
        end
        if (last) begin
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic set_grid(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        settle_block();
        cfg_write(REG_GRID_WIDTH, w, 1'b0);
        cfg_write(REG_GRID_HEIGHT, h, 1'b1);
    endtask

    // A step with an empty stack reports finished.
    task automatic test_step_before_start();
        send_item(CMD_STEP, 8'hFF);
    endtask

    // First carves on the reset-size grid with extreme and alternating picks.
    task automatic test_first_moves();
        send_item(CMD_START, 8'h00);
        send_item(CMD_STEP, 8'h00);
        send_item(CMD_STEP, 8'hFF);
        send_item(CMD_STEP, 8'hAA);
        send_item(CMD_STEP, 8'h55);
        send_item(CMD_STEP, 8'h01);
    endtask

    // Shrink to a single cell mid-maze, pop the stack empty, step once more, then start again and step.
    task automatic test_resize_and_unwind();
        set_grid(7'd0, 7'd2);
        while (maze_depth > 0) begin
            send_item(CMD_STEP, 8'hFF);
        end
        send_item(CMD_STEP, 8'h00);
        send_item(CMD_START, 8'hFF);
        send_item(CMD_STEP, 8'h80);
        send_item(CMD_STEP, 8'h7F);
    endtask

    // Oversize and even sizes, plus a write to an index with no register.
    task automatic test_size_extremes();
        settle_block();
        cfg_write(REG_UNUSED, 7'h7F, 1'b0);
        cfg_write(REG_GRID_WIDTH, 7'd127, 1'b0);
        cfg_write(REG_GRID_HEIGHT, 7'd1, 1'b1);
        send_item(CMD_START, 8'h00);
        send_item(CMD_STEP, 8'hFF);
        send_item(CMD_STEP, 8'h00);
        send_item(CMD_STEP, 8'hFF);
        set_grid(7'd66, 7'd64);
        send_item(CMD_START, 8'h00);
        send_item(CMD_STEP, 8'h02);
        send_item(CMD_STEP, 8'hFE);
    endtask

    // Random mazes: mostly full runs on small grids, with restarts, resizes and stray items.
    task automatic test_random_mazes(input int n_items, input int pct);
        int base, w, h, budget, tail, r, left;
        idle_pct = pct;
        base = items_sent;
        while (items_sent - base < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                w = $urandom_range(0, 21);
                h = $urandom_range(0, 21);
            end else if (r < 88) begin
                w = $urandom_range(0, 41);
                h = $urandom_range(0, 41);
            end else begin
                w = $urandom_range(0, 127);
                h = $urandom_range(0, 127);
            end
            set_grid(7'(w), 7'(h));
            send_item(CMD_START, 8'($urandom_range(0, 255)));
            budget = 2 * cells_on_axis(7'(w), CELLS_X) * cells_on_axis(7'(h), CELLS_Y) + 3;
            if (budget > 240) begin
                budget = 240;
            end
            left = n_items - (items_sent - base);
            if (budget > left) begin
                budget = left;
            end
            tail = $urandom_range(1, 2);
            for (int i = 0; i < budget; i++) begin
                // A few steps past the end of the maze report finished.
                if (maze_depth == 0) begin
                    if (tail == 0) begin
                        break;
                    end
                    tail--;
                end
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    send_item(CMD_START, 8'($urandom_range(0, 255)));
                end else if (r < 4) begin
                    set_grid(7'($urandom_range(0, 21)), 7'($urandom_range(0, 21)));
                    send_item(CMD_STEP, 8'($urandom_range(0, 255)));
                end else if (r < 6) begin
                    send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end else begin
                    send_item(CMD_STEP, 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_step_before_start();
        test_first_moves();
        test_resize_and_unwind();
        test_size_extremes();
        test_random_mazes(300, 0);
        test_random_mazes(300, 58);
        test_random_mazes(300, 20);
        settle_block();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
